@@ hdl/tpl_pkg.sv @@
// Shared types, opcodes, fee rates and helper functions of the trade position ledger.
// No dependencies; used by trade_position_ledger and tpl_div.
package tpl_pkg;

  // Request and response payloads
  typedef struct packed {
    logic [1:0]  opcode;
    logic [7:0]  symbol;
    logic        side;
    logic [31:0] price;
    logic [23:0] quantity;
    logic [1:0]  contract_kind;
  } tpl_req_t;

  typedef struct packed {
    logic               result_kind;
    logic [7:0]         result_symbol;
    logic               symbol_active;
    logic signed [63:0] value;
  } tpl_rsp_t;

  // One ledger entry per symbol
  typedef struct packed {
    logic [63:0] buy_value;
    logic [63:0] sell_value;
    logic [31:0] buy_qty;
    logic [31:0] sell_qty;
    logic [31:0] buy_count;
    logic [31:0] sell_count;
    logic [63:0] buy_fee;
    logic [63:0] sell_fee;
    logic [31:0] last_price;
    logic        valid;
  } tpl_rec_t;

  localparam logic [1:0] OP_TRADE = 2'd0;
  localparam logic [1:0] OP_MARK  = 2'd1;
  localparam logic [1:0] OP_EXPO  = 2'd2;

  localparam logic [1:0] MODE_EQUITY  = 2'd0;
  localparam logic [1:0] MODE_DERIV   = 2'd1;
  localparam logic [1:0] MODE_FUTURES = 2'd2;

  localparam logic [1:0] KIND_T = 2'd0;
  localparam logic [1:0] KIND_E = 2'd1;

  localparam logic       RES_PROFIT   = 1'b0;
  localparam logic       RES_EXPOSURE = 1'b1;

  // Fee rates in 1e-6 units per paisa of notional
  localparam int unsigned RATE_W = 11;
  localparam logic [RATE_W-1:0] RATE_EQ_BUY  = 11'd40;
  localparam logic [RATE_W-1:0] RATE_EQ_SELL = 11'd290;
  localparam logic [RATE_W-1:0] RATE_T_BUY   = 11'd25;
  localparam logic [RATE_W-1:0] RATE_T_SELL  = 11'd125;
  localparam logic [RATE_W-1:0] RATE_E_BUY   = 11'd560;
  localparam logic [RATE_W-1:0] RATE_E_SELL  = 11'd1060;

  localparam int unsigned REM_W     = 20;
  localparam int unsigned FEE_SCALE = 1000000;

  // Look up the fee rate for a mode, contract kind and side
  function automatic logic [RATE_W-1:0] fee_rate(input logic [1:0] mode,
                                                 input logic [1:0] kind,
                                                 input logic       sell);
    logic [RATE_W-1:0] r;
    r = '0;
    case (mode)
      MODE_EQUITY: begin
        r = sell ? RATE_EQ_SELL : RATE_EQ_BUY;
      end
      MODE_DERIV: begin
        if (kind == KIND_T) begin
          r = sell ? RATE_T_SELL : RATE_T_BUY;
        end else if (kind == KIND_E) begin
          r = sell ? RATE_E_SELL : RATE_E_BUY;
        end
      end
      MODE_FUTURES: begin
        r = sell ? RATE_T_SELL : RATE_T_BUY;
      end
      default: begin
        r = '0;
      end
    endcase
    return r;
  endfunction

  // Magnitude of buy minus sell quantity read as two's complement
  function automatic logic [31:0] net_mag(input logic [31:0] bq, input logic [31:0] sq);
    logic [31:0] d;
    d = bq - sq;
    return d[31] ? (32'd0 - d) : d;
  endfunction

endpackage

@@ hdl/tpl_div.sv @@
// Divider of a 64-bit fee total by the fixed fee scale: four 16-bit digits, each formed by
// a reciprocal multiply for the digit and then a subtract for the remainder.
// Depends on tpl_pkg for the scale and remainder width.
module tpl_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] dividend_i,
  output logic        done_o,
  output logic [63:0] quotient_o
);
  import tpl_pkg::*;

  localparam int unsigned DIG_W    = 16;
  localparam int unsigned CUR_W    = REM_W + DIG_W;
  localparam int unsigned RECIP_SH = 45;
  // Rounded-up 2^45 / 15625; the scale is 2^6 * 15625
  localparam logic [31:0] RECIP    = 32'd2251799814;
  localparam logic [CUR_W-1:0] SCALE_C = CUR_W'(FEE_SCALE);

  logic              busy_q;
  logic              phase_q;
  logic              done_q;
  logic [1:0]        cnt_q;
  logic [REM_W-1:0]  rem_q;
  logic [63:0]       dvd_q;
  logic [63:0]       quo_q;
  logic [61:0]       est_q;
  logic [CUR_W-1:0]  cur;
  logic [29:0]       cur_hi;
  logic [DIG_W-1:0]  qd;
  logic [CUR_W-1:0]  back;
  logic [CUR_W-1:0]  rem_next;

  // Partial dividend: remainder so far with the next 16-bit digit
  assign cur      = {rem_q, dvd_q[63:48]};
  assign cur_hi   = cur[CUR_W-1:6];
  assign qd       = est_q[RECIP_SH+DIG_W-1:RECIP_SH];
  assign back     = CUR_W'(qd) * SCALE_C;
  assign rem_next = cur - back;

  // Control: an estimate phase and a remainder phase per digit, four digits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      phase_q <= 1'b0;
      done_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q  <= 1'b1;
        phase_q <= 1'b0;
        cnt_q   <= '0;
      end else if (busy_q) begin
        phase_q <= !phase_q;
        if (phase_q) begin
          cnt_q <= cnt_q + 2'd1;
          if (cnt_q == 2'd3) begin
            busy_q <= 1'b0;
            done_q <= 1'b1;
          end
        end
      end
    end
  end

  // Datapath: estimate the digit, then take the remainder and shift the digit in
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      rem_q <= '0;
      quo_q <= '0;
    end else if (busy_q) begin
      if (!phase_q) begin
        est_q <= {32'd0, cur_hi} * {30'd0, RECIP};
      end else begin
        rem_q <= rem_next[REM_W-1:0];
        dvd_q <= {dvd_q[47:0], 16'd0};
        quo_q <= {quo_q[47:0], qd};
      end
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

@@ hdl/trade_position_ledger.sv @@
// Top level of the trade position ledger: entry memory, sequencer and shared multiplier.
// Depends on tpl_pkg and tpl_div.
//
// After reset the block clears its entry memory, one symbol per cycle, and accepts no
// request until that is done; cost_mode writes are taken at any time. It then takes one
// request at a time. A trade passes through the accept cycle with its memory read, five
// steps of a single shared 32x32 multiplier (notional, old exposure, two fee halves, new
// exposure) and a write back. A mark passes through the accept cycle, the steps that form
// the held notional and the closing fee, a step that forms the base profit and starts the
// divider, the division of the fee total by 1e6 (four 16-bit digits, each a reciprocal
// multiply and a subtract) and the output state. An exposure query goes from the accept
// cycle to the output state. Ignored requests (unused opcode, symbol out of range) end in
// the accept cycle. Results sit in an output register, so the next request is taken while
// a result waits; a new result holds in the output state until the register drains.
module trade_position_ledger #(
  parameter int unsigned SYMBOLS = 256
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  tpl_pkg::tpl_req_t in_req_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output tpl_pkg::tpl_rsp_t out_rsp_o
);
  import tpl_pkg::*;

  localparam int unsigned AW = (SYMBOLS > 1) ? $clog2(SYMBOLS) : 1;

  localparam logic [3:0] ST_CLR  = 4'd0;
  localparam logic [3:0] ST_IDLE = 4'd1;
  localparam logic [3:0] ST_T0   = 4'd2;
  localparam logic [3:0] ST_T1   = 4'd3;
  localparam logic [3:0] ST_T2   = 4'd4;
  localparam logic [3:0] ST_T3   = 4'd5;
  localparam logic [3:0] ST_T4   = 4'd6;
  localparam logic [3:0] ST_T5   = 4'd7;
  localparam logic [3:0] ST_M0   = 4'd8;
  localparam logic [3:0] ST_M1   = 4'd9;
  localparam logic [3:0] ST_M2   = 4'd10;
  localparam logic [3:0] ST_M3   = 4'd11;
  localparam logic [3:0] ST_M4   = 4'd12;
  localparam logic [3:0] ST_M5   = 4'd13;
  localparam logic [3:0] ST_OUT  = 4'd14;

  tpl_rec_t    mem [SYMBOLS];

  logic [3:0]  state_q;
  logic [AW-1:0] clr_q;
  logic [1:0]  mode_q;
  logic        out_valid_q;
  logic [63:0] exposure_q;
  tpl_req_t    req_q;
  tpl_rec_t    rd_q;
  tpl_rsp_t    res_q;
  tpl_rsp_t    out_q;
  logic [63:0] prod_q;
  logic [63:0] p_q;
  logic [63:0] eo_q;
  logic [63:0] f_q;
  logic [63:0] held_q;
  logic [63:0] cf_q;
  logic [63:0] base_q;

  logic        in_acc;
  logic        in_range;
  logic [31:0] sym_ext;
  logic [31:0] wr_ext;
  logic [31:0] qty32;
  logic [31:0] net_old;
  logic [31:0] mag_old;
  logic [31:0] mag_new;
  logic        close_sell;
  logic [RATE_W-1:0] rate_trade;
  logic [RATE_W-1:0] rate_close;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  tpl_rec_t    new_rec;
  logic        mem_we;
  logic [AW-1:0] wr_addr;
  tpl_rec_t    wr_data;
  logic        out_load;
  logic        div_start;
  logic        div_done;
  logic [63:0] div_quot;
  logic [63:0] fee_sum;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign sym_ext    = {24'd0, in_req_i.symbol};
  assign in_range   = (sym_ext < 32'(SYMBOLS));
  assign wr_ext     = {24'd0, req_q.symbol};
  assign qty32      = {8'd0, req_q.quantity};

  // Position of the entry as read
  assign net_old    = rd_q.buy_qty - rd_q.sell_qty;
  assign mag_old    = net_mag(rd_q.buy_qty, rd_q.sell_qty);
  assign close_sell = !net_old[31] && (mag_old != 32'd0);
  assign rate_trade = fee_rate(mode_q, req_q.contract_kind, req_q.side);
  assign rate_close = fee_rate(mode_q, req_q.contract_kind, close_sell);

  // Build the updated entry for a trade
  always_comb begin
    new_rec            = rd_q;
    new_rec.last_price = req_q.price;
    new_rec.valid      = 1'b1;
    if (req_q.side) begin
      new_rec.sell_value = rd_q.sell_value + p_q;
      new_rec.sell_qty   = rd_q.sell_qty + qty32;
      new_rec.sell_count = rd_q.sell_count + 32'd1;
      new_rec.sell_fee   = rd_q.sell_fee + f_q;
    end else begin
      new_rec.buy_value  = rd_q.buy_value + p_q;
      new_rec.buy_qty    = rd_q.buy_qty + qty32;
      new_rec.buy_count  = rd_q.buy_count + 32'd1;
      new_rec.buy_fee    = rd_q.buy_fee + f_q;
    end
  end

  assign mag_new = net_mag(new_rec.buy_qty, new_rec.sell_qty);

  // Select multiplier operands by step
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_T0: begin
        mul_a = req_q.price;
        mul_b = qty32;
      end
      ST_T1: begin
        mul_a = mag_old;
        mul_b = rd_q.last_price;
      end
      ST_T2: begin
        mul_a = p_q[31:0];
        mul_b = 32'(rate_trade);
      end
      ST_T3: begin
        mul_a = p_q[63:32];
        mul_b = 32'(rate_trade);
      end
      ST_T4: begin
        mul_a = mag_new;
        mul_b = req_q.price;
      end
      ST_M0: begin
        mul_a = mag_old;
        mul_b = req_q.price;
      end
      ST_M1: begin
        mul_a = prod_q[31:0];
        mul_b = 32'(rate_close);
      end
      ST_M2: begin
        mul_a = held_q[63:32];
        mul_b = 32'(rate_close);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Entry memory: clear sweep or trade write back, read on request
  assign mem_we  = (state_q == ST_CLR) || (state_q == ST_T5);
  assign wr_addr = (state_q == ST_CLR) ? clr_q : wr_ext[AW-1:0];
  assign wr_data = (state_q == ST_CLR) ? '0 : new_rec;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    if (in_acc && in_range) begin
      rd_q <= mem[sym_ext[AW-1:0]];
    end
  end

  // Fee total and the divider
  assign fee_sum   = rd_q.buy_fee + rd_q.sell_fee + cf_q;
  assign div_start = (state_q == ST_M4);

  tpl_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (fee_sum),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  assign out_load = (state_q == ST_OUT) && (!out_valid_q || out_ready_i);

  // Sequencer, configuration, exposure total and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLR;
      clr_q       <= '0;
      mode_q      <= MODE_EQUITY;
      out_valid_q <= 1'b0;
      exposure_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        mode_q <= cfg_data_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_CLR: begin
          clr_q <= clr_q + AW'(1);
          if (clr_q == AW'(SYMBOLS - 1)) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_acc) begin
            if (in_req_i.opcode == OP_EXPO) begin
              state_q <= ST_OUT;
            end else if (in_req_i.opcode == OP_TRADE && in_range) begin
              state_q <= ST_T0;
            end else if (in_req_i.opcode == OP_MARK && in_range) begin
              state_q <= ST_M0;
            end
          end
        end
        ST_T0: state_q <= ST_T1;
        ST_T1: state_q <= ST_T2;
        ST_T2: state_q <= ST_T3;
        ST_T3: state_q <= ST_T4;
        ST_T4: state_q <= ST_T5;
        ST_T5: begin
          exposure_q <= exposure_q - eo_q + prod_q;
          state_q    <= ST_IDLE;
        end
        ST_M0: state_q <= ST_M1;
        ST_M1: state_q <= ST_M2;
        ST_M2: state_q <= ST_M3;
        ST_M3: state_q <= ST_M4;
        ST_M4: state_q <= ST_M5;
        ST_M5: begin
          if (div_done) begin
            state_q <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_load) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    prod_q <= 64'(mul_a) * 64'(mul_b);
    if (in_acc) begin
      req_q                <= in_req_i;
      res_q.result_kind    <= RES_EXPOSURE;
      res_q.result_symbol  <= '0;
      res_q.symbol_active  <= 1'b0;
      res_q.value          <= exposure_q;
    end
    case (state_q)
      ST_T1: p_q  <= prod_q;
      ST_T2: eo_q <= prod_q;
      ST_T3: f_q  <= prod_q;
      ST_T4: f_q  <= f_q + {prod_q[31:0], 32'd0};
      ST_M1: held_q <= prod_q;
      ST_M2: cf_q <= prod_q;
      ST_M3: cf_q <= cf_q + {prod_q[31:0], 32'd0};
      ST_M4: begin
        base_q <= net_old[31] ? (rd_q.sell_value - rd_q.buy_value - held_q)
                              : (rd_q.sell_value - rd_q.buy_value + held_q);
      end
      ST_M5: begin
        if (div_done) begin
          res_q.result_kind   <= RES_PROFIT;
          res_q.result_symbol <= req_q.symbol;
          res_q.symbol_active <= rd_q.valid;
          res_q.value         <= base_q - div_quot;
        end
      end
      default: begin
      end
    endcase
    if (out_load) begin
      out_q <= res_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  // Memory is never written in a cycle that takes a request
  a_no_write_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> !in_acc) else $error("entry write while taking a request");

  // A trade never heads for the output stage
  a_trade_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_req_i.opcode == OP_TRADE) |=> (state_q == ST_T0 || state_q == ST_IDLE))
    else $error("trade request took a wrong path");

  // The divider does not finish right after a start
  a_div_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |=> !div_done) else $error("divider finished too early");

  // No request is taken during the clear sweep
  a_clear_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLR) |-> !in_ready_o) else $error("request taken while clearing");

endmodule

@@ tb/trade_position_ledger_tb.sv @@
// Self-checking testbench of trade_position_ledger: directed and random requests, with its
// own fee and profit predictor checked against every response. Depends on tpl_pkg and the RTL.
module trade_position_ledger_tb;
  import tpl_pkg::*;

  localparam int unsigned NSYM       = 256;
  localparam int unsigned IDLE_LIMIT = 5000;
  localparam int unsigned SETTLE     = 100;

  logic      clk_i;
  logic      rst_ni;
  logic      cfg_we_i;
  logic [1:0] cfg_data_i;
  logic      in_valid_i;
  logic      in_ready_o;
  tpl_req_t  in_req_i;
  logic      out_valid_o;
  logic      out_ready_i;
  tpl_rsp_t  out_rsp_o;

  trade_position_ledger #(.SYMBOLS(NSYM)) i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o)
  );

  // Predicted ledger state
  logic [63:0] buy_val_q  [NSYM];
  logic [63:0] sell_val_q [NSYM];
  logic [31:0] buy_qty_q  [NSYM];
  logic [31:0] sell_qty_q [NSYM];
  logic [63:0] buy_fee_q  [NSYM];
  logic [63:0] sell_fee_q [NSYM];
  logic [31:0] last_px_q  [NSYM];
  logic        traded_q   [NSYM];
  logic [63:0] exposure_q;
  logic [1:0]  mode_q;

  tpl_rsp_t    expected_rsp_q[$];
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned mismatch_cnt;
  int unsigned request_cnt;
  int unsigned response_cnt;
  int unsigned idle_cycles;

  // Clock
  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Fee rate table in 1e-6 units per paisa
  function automatic logic [63:0] rate_of(input logic [1:0] mode, input logic [1:0] kind,
                                          input logic sell);
    case (mode)
      MODE_EQUITY:  return sell ? 64'd290 : 64'd40;
      MODE_DERIV: begin
        if (kind == KIND_T) return sell ? 64'd125 : 64'd25;
        if (kind == KIND_E) return sell ? 64'd1060 : 64'd560;
        return 64'd0;
      end
      MODE_FUTURES: return sell ? 64'd125 : 64'd25;
      default:      return 64'd0;
    endcase
  endfunction

  function automatic logic [31:0] net_size(input int unsigned s);
    logic [31:0] d;
    d = buy_qty_q[s] - sell_qty_q[s];
    return d[31] ? (32'd0 - d) : d;
  endfunction

  function automatic logic [63:0] symbol_exposure(input int unsigned s);
    return {32'd0, net_size(s)} * {32'd0, last_px_q[s]};
  endfunction

  // Update the predicted ledger and queue the response an accepted request causes
  task automatic predict_request(input tpl_req_t r);
    logic [63:0] px, qty, fee, held, close_fee, fees, v;
    logic [31:0] d, mag;
    logic        neg;
    int unsigned s;
    tpl_rsp_t    rsp;
    px  = {32'd0, r.price};
    qty = {40'd0, r.quantity};
    s   = {24'd0, r.symbol};
    if (r.opcode == OP_EXPO) begin
      rsp = '{result_kind: RES_EXPOSURE, result_symbol: 8'd0, symbol_active: 1'b0,
              value: exposure_q};
      expected_rsp_q.insert(expected_rsp_q.size(), rsp);
    end else if (r.opcode == OP_TRADE) begin
      fee = qty * px * rate_of(mode_q, r.contract_kind, r.side);
      exposure_q = exposure_q - symbol_exposure(s);
      last_px_q[s] = r.price;
      if (r.side) begin
        sell_val_q[s] = sell_val_q[s] + px * qty;
        sell_qty_q[s] = sell_qty_q[s] + {8'd0, r.quantity};
        sell_fee_q[s] = sell_fee_q[s] + fee;
      end else begin
        buy_val_q[s] = buy_val_q[s] + px * qty;
        buy_qty_q[s] = buy_qty_q[s] + {8'd0, r.quantity};
        buy_fee_q[s] = buy_fee_q[s] + fee;
      end
      traded_q[s] = 1'b1;
      exposure_q = exposure_q + symbol_exposure(s);
    end else if (r.opcode == OP_MARK) begin
      d   = buy_qty_q[s] - sell_qty_q[s];
      neg = d[31];
      mag = net_size(s);
      held = {32'd0, mag} * px;
      close_fee = {32'd0, mag} * px *
                  rate_of(mode_q, r.contract_kind, !neg && (mag != 32'd0));
      fees = (buy_fee_q[s] + sell_fee_q[s] + close_fee) / 64'd1000000;
      v = sell_val_q[s] - buy_val_q[s];
      v = neg ? v - held : v + held;
      v = v - fees;
      rsp = '{result_kind: RES_PROFIT, result_symbol: r.symbol, symbol_active: traded_q[s],
              value: v};
      expected_rsp_q.insert(expected_rsp_q.size(), rsp);
    end
  endtask

  // Send one request; valid is only lowered while idling
  task automatic send_request(input tpl_req_t r);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= r;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    request_cnt++;
    predict_request(r);
  endtask

  function automatic tpl_req_t make_req(input logic [1:0] op, input logic [7:0] sym,
                                        input logic side, input logic [31:0] px,
                                        input logic [23:0] qty, input logic [1:0] kind);
    tpl_req_t r;
    r.opcode = op;
    r.symbol = sym;
    r.side = side;
    r.price = px;
    r.quantity = qty;
    r.contract_kind = kind;
    return r;
  endfunction

  // Drain, let trailing work finish, then write the fee mode
  task automatic set_cost_mode(input logic [1:0] m);
    in_valid_i <= 1'b0;
    while (expected_rsp_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= m;
    mode_q = m;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Extremes, every opcode and the special cases
  task automatic test_directed();
    send_request(make_req(OP_MARK, 8'd200, 1'b0, 32'hFFFF_FFFF, 24'd0, KIND_T));
    send_request(make_req(OP_EXPO, 8'hFF, 1'b1, 32'hFFFF_FFFF, 24'hFF_FFFF, 2'd3));
    send_request(make_req(OP_TRADE, 8'd0, 1'b0, 32'hFFFF_FFFF, 24'hFF_FFFF, KIND_T));
    send_request(make_req(OP_TRADE, 8'd0, 1'b1, 32'd1, 24'd1, KIND_E));
    send_request(make_req(OP_MARK, 8'd0, 1'b0, 32'hFFFF_FFFF, 24'd0, KIND_E));
    send_request(make_req(OP_TRADE, 8'hFF, 1'b1, 32'd12345, 24'hFF_FFFF, 2'd3));
    send_request(make_req(OP_MARK, 8'hFF, 1'b1, 32'd0, 24'hFF_FFFF, 2'd3));
    send_request(make_req(OP_MARK, 8'hFF, 1'b0, 32'd99999, 24'd0, KIND_T));
    send_request(make_req(2'd3, 8'd5, 1'b1, 32'hFFFF_FFFF, 24'hFF_FFFF, 2'd3));
    send_request(make_req(OP_TRADE, 8'd7, 1'b0, 32'd0, 24'd0, 2'd2));
    send_request(make_req(OP_MARK, 8'd7, 1'b0, 32'd500, 24'd0, 2'd2));
    send_request(make_req(OP_EXPO, 8'd0, 1'b0, 32'd0, 24'd0, KIND_T));
  endtask

  // Drive one symbol short by exactly 2^31 so the net wraps to its largest magnitude
  task automatic test_net_wrap();
    for (int i = 0; i < 128; i++) begin
      send_request(make_req(OP_TRADE, 8'd9, 1'b1, 32'hFFFF_FFFF, 24'hFF_FFFF, KIND_T));
      send_request(make_req(OP_TRADE, 8'd9, 1'b1, 32'd777, 24'd1, KIND_E));
    end
    send_request(make_req(OP_MARK, 8'd9, 1'b0, 32'hFFFF_FFFF, 24'd0, KIND_T));
    send_request(make_req(OP_EXPO, 8'd0, 1'b0, 32'd0, 24'd0, KIND_T));
  endtask

  function automatic logic [31:0] rand_price();
    int unsigned c;
    c = $urandom_range(0, 9);
    if (c == 0) return 32'hFFFF_FFFF;
    if (c == 1) return 32'd0;
    if (c < 6)  return $urandom_range(1, 100000);
    return $urandom;
  endfunction

  function automatic logic [23:0] rand_qty();
    int unsigned c;
    c = $urandom_range(0, 9);
    if (c == 0) return 24'hFF_FFFF;
    if (c == 1) return 24'd0;
    if (c < 6)  return 24'($urandom_range(1, 1000));
    return 24'($urandom);
  endfunction

  // Mostly trades and marks on a few hot symbols, some queries and unused opcodes
  task automatic test_random(input int unsigned n);
    int unsigned c;
    logic [1:0]  op;
    logic [7:0]  sym;
    for (int unsigned i = 0; i < n; i++) begin
      c = $urandom_range(0, 99);
      op = (c < 55) ? OP_TRADE : (c < 85) ? OP_MARK : (c < 95) ? OP_EXPO : 2'd3;
      sym = ($urandom_range(0, 9) < 8) ? 8'($urandom_range(0, 7)) : 8'($urandom);
      send_request(make_req(op, sym, 1'($urandom), rand_price(), rand_qty(),
                            2'($urandom_range(0, 3))));
    end
  endtask

  // Check each response against the oldest prediction; randomize the stall
  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) begin
      response_cnt++;
      if (expected_rsp_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) $display("unexpected response %p", out_rsp_o);
      end else begin
        if (out_rsp_o.result_kind !== expected_rsp_q[0].result_kind ||
            out_rsp_o.result_symbol !== expected_rsp_q[0].result_symbol ||
            out_rsp_o.symbol_active !== expected_rsp_q[0].symbol_active ||
            out_rsp_o.value !== expected_rsp_q[0].value) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) begin
            $display("response %0d: expected %p, got %p", response_cnt,
                     expected_rsp_q[0], out_rsp_o);
          end
        end
        void'(expected_rsp_q.pop_front());
      end
    end
    out_ready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Watchdog on cycles with no handshake
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("trade_position_ledger: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    in_req_i = '0;
    out_ready_i = 1'b0;
    idle_cycles = 0;
    mismatch_cnt = 0;
    request_cnt = 0;
    response_cnt = 0;
    send_idle_pct = 7;
    recv_stall_pct = 58;
    mode_q = MODE_EQUITY;
    exposure_q = '0;
    for (int i = 0; i < NSYM; i++) begin
      buy_val_q[i] = '0;
      sell_val_q[i] = '0;
      buy_qty_q[i] = '0;
      sell_qty_q[i] = '0;
      buy_fee_q[i] = '0;
      sell_fee_q[i] = '0;
      last_px_q[i] = '0;
      traded_q[i] = 1'b0;
    end
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_net_wrap();
    test_random(250);
    set_cost_mode(MODE_DERIV);
    test_random(250);
    send_idle_pct = 58;
    recv_stall_pct = 7;
    set_cost_mode(MODE_FUTURES);
    test_random(250);
    set_cost_mode(2'd3);
    test_random(200);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    set_cost_mode(MODE_DERIV);
    test_random(200);
    set_cost_mode(MODE_EQUITY);
    test_random(200);

    in_valid_i <= 1'b0;
    while (expected_rsp_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    $display("ran %0d requests and checked %0d responses over all four fee modes",
             request_cnt, response_cnt);
    $display("covered extreme prices and sizes, untraded marks and a wrapped net position");
    if (mismatch_cnt == 0 && expected_rsp_q.size() == 0) begin
      $display("trade_position_ledger: match");
    end else begin
      $display("trade_position_ledger: mismatch");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/tpl_pkg.sv
hdl/tpl_div.sv
hdl/trade_position_ledger.sv
tb/trade_position_ledger_tb.sv
